[rtl/pdf_lsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// PDF literal string decoder package
// Shared types, character codes and the escape table of the decoder.
// ----------------------------------------------------------------------------
package pdf_lsd_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned KIND_W       = 2;
    localparam int unsigned LEN_W        = 16;
    localparam int unsigned OCT_W        = 9;
    localparam int unsigned FIFO_DEPTH   = 4;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd32767;
    localparam logic [LEN_W-1:0] DEPTH_MAX        = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_SEVEN  = 8'h37;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
    localparam logic [BYTE_W-1:0] CH_F      = 8'h66;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        kind_t             kind;
    } res_t;

    typedef struct packed {
        logic two;
        res_t res0;
        res_t res1;
    } entry_t;

    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] data;
    } esc_t;

    function automatic esc_t esc_map(input logic [BYTE_W-1:0] b);
        esc_t r;
        r.hit  = 1'b1;
        r.data = b;
        unique case (b)
            CH_N:      r.data = 8'h0A;
            CH_R:      r.data = 8'h0D;
            CH_T:      r.data = 8'h09;
            CH_B:      r.data = 8'h08;
            CH_F:      r.data = 8'h0C;
            CH_LPAREN,
            CH_RPAREN,
            CH_BSLASH: r.data = b;
            default:   r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_octal(input logic [BYTE_W-1:0] b);
        return (b >= CH_ZERO) && (b <= CH_SEVEN);
    endfunction

endpackage
`default_nettype wire

[rtl/pdf_lsd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// PDF literal string decoder front end
// Accepts raw bytes, tracks string state and classifies each byte into zero,
// one or two result records for the queue.
// ----------------------------------------------------------------------------
module pdf_lsd_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [pdf_lsd_pkg::LEN_W-1:0]  cfg_wdata,
    input  wire logic                           in_valid,
    input  wire logic [pdf_lsd_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                           in_end,
    input  wire logic                           q_full,
    output logic                                in_ready,
    output logic                                push,
    output pdf_lsd_pkg::entry_t                 push_entry
);
    import pdf_lsd_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic             in_str_reg, in_str_next;
    logic             esc_reg, esc_next;
    logic [OCT_W-1:0] oval_reg, oval_next;
    logic [1:0]       odig_reg, odig_next;
    logic [LEN_W-1:0] depth_reg, depth_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;

    res_t             flush_res, main_res;
    logic             flush_vld, main_vld, go_idle;
    logic [LEN_W-1:0] cnt_use;
    esc_t             em;
    logic             accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign em       = esc_map(in_byte);

    always_comb begin
        in_str_next = in_str_reg;
        esc_next    = esc_reg;
        oval_next   = oval_reg;
        odig_next   = odig_reg;
        depth_next  = depth_reg;
        cnt_next    = cnt_reg;
        flush_vld   = 1'b0;
        main_vld    = 1'b0;
        flush_res   = '{data: '0, kind: KIND_DATA};
        main_res    = '{data: '0, kind: KIND_DATA};
        go_idle     = 1'b0;
        cnt_use     = cnt_reg;
        if (!in_str_reg) begin
            if (!in_end) begin
                if (in_byte == CH_LPAREN) begin
                    go_idle     = 1'b1;
                    in_str_next = 1'b1;
                end else begin
                    main_vld      = 1'b1;
                    main_res.kind = KIND_ERROR;
                    go_idle       = 1'b1;
                end
            end
        end else if (in_end) begin
            main_vld      = 1'b1;
            main_res.kind = KIND_ERROR;
            go_idle       = 1'b1;
        end else if (esc_reg) begin
            esc_next = 1'b0;
            if (is_octal(in_byte)) begin
                oval_next = OCT_W'(in_byte - CH_ZERO);
                odig_next = 2'd1;
            end else begin
                main_vld = 1'b1;
                if (!em.hit || cnt_reg >= max_len_reg) begin
                    main_res.kind = KIND_ERROR;
                    go_idle       = 1'b1;
                end else begin
                    main_res.data = em.data;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
        end else if (odig_reg != 2'd0 && odig_reg != 2'd3 && is_octal(in_byte)) begin
            oval_next = {oval_reg[OCT_W-4:0], in_byte[2:0]};
            odig_next = odig_reg + 1'b1;
        end else begin
            if (odig_reg != 2'd0) begin
                flush_vld = 1'b1;
                odig_next = 2'd0;
                oval_next = '0;
                if (cnt_reg >= max_len_reg) begin
                    flush_res.kind = KIND_ERROR;
                    go_idle        = 1'b1;
                end else begin
                    flush_res.data = oval_reg[BYTE_W-1:0];
                    cnt_use        = cnt_reg + 1'b1;
                    cnt_next       = cnt_use;
                end
            end
            if (!go_idle) begin
                priority if (in_byte == CH_BSLASH) begin
                    esc_next = 1'b1;
                end else if (in_byte == CH_RPAREN && depth_reg == '0) begin
                    main_vld      = 1'b1;
                    main_res.kind = KIND_END;
                    go_idle       = 1'b1;
                end else if ((in_byte == CH_LPAREN && depth_reg == DEPTH_MAX)
                             || cnt_use >= max_len_reg) begin
                    main_vld      = 1'b1;
                    main_res.kind = KIND_ERROR;
                    go_idle       = 1'b1;
                end else begin
                    main_vld      = 1'b1;
                    main_res.data = in_byte;
                    cnt_next      = cnt_use + 1'b1;
                    if (in_byte == CH_LPAREN) begin
                        depth_next = depth_reg + 1'b1;
                    end else if (in_byte == CH_RPAREN) begin
                        depth_next = depth_reg - 1'b1;
                    end
                end
            end
        end
        if (go_idle) begin
            esc_next   = 1'b0;
            oval_next  = '0;
            odig_next  = 2'd0;
            depth_next = '0;
            cnt_next   = '0;
            if (in_str_reg || in_byte != CH_LPAREN || in_end) begin
                in_str_next = 1'b0;
            end
        end
    end

    always_comb begin
        push = accept && (flush_vld || main_vld);
        if (flush_vld) begin
            push_entry = '{two: main_vld, res0: flush_res, res1: main_res};
        end else begin
            push_entry = '{two: 1'b0, res0: main_res, res1: main_res};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LENGTH_RESET;
            in_str_reg  <= 1'b0;
            esc_reg     <= 1'b0;
            oval_reg    <= '0;
            odig_reg    <= 2'd0;
            depth_reg   <= '0;
            cnt_reg     <= '0;
        end else begin
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            if (accept) begin
                in_str_reg <= in_str_next;
                esc_reg    <= esc_next;
                oval_reg   <= oval_next;
                odig_reg   <= odig_next;
                depth_reg  <= depth_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/pdf_lsd_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// PDF literal string decoder result queue
// Short register queue of result records between the front and back ends.
// ----------------------------------------------------------------------------
module pdf_lsd_fifo #(
    parameter int unsigned DEPTH = pdf_lsd_pkg::FIFO_DEPTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire pdf_lsd_pkg::entry_t push_entry,
    input  wire logic                pop,
    output logic                     full,
    output logic                     not_empty,
    output pdf_lsd_pkg::entry_t      head
);
    import pdf_lsd_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t          mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/pdf_lsd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// PDF literal string decoder back end
// Takes result records from the queue and sends their one or two results
// on the output stream.
// ----------------------------------------------------------------------------
module pdf_lsd_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_not_empty,
    input  wire pdf_lsd_pkg::entry_t            q_head,
    output logic                                q_pop,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [pdf_lsd_pkg::BYTE_W-1:0]      out_byte,
    output logic [pdf_lsd_pkg::KIND_W-1:0]      out_kind,
    output logic                                out_last
);
    import pdf_lsd_pkg::*;

    logic   valid_reg;
    logic   phase_reg;
    entry_t ent_reg;
    res_t   cur;
    logic   done;

    assign cur       = phase_reg ? ent_reg.res1 : ent_reg.res0;
    assign out_valid = valid_reg;
    assign out_byte  = cur.data;
    assign out_kind  = cur.kind;
    assign out_last  = !ent_reg.two || phase_reg;
    assign done      = !valid_reg || (out_ready && out_last);
    assign q_pop     = done && q_not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else if (done) begin
            valid_reg <= q_not_empty;
            phase_reg <= 1'b0;
        end else if (out_ready) begin
            phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg <= q_head;
        end
    end

endmodule
`default_nettype wire

[rtl/pdf_literal_string_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// PDF literal string decoder
// Decodes PDF literal strings from a byte stream into data bytes, end
// markers and errors.
// ----------------------------------------------------------------------------
// The block takes one raw byte per cycle and each byte leaves the front end
// in the cycle it is accepted. A byte gives zero, one or two results; the
// output port sends one result per cycle while m_tready is high, so a
// byte that flushes a pending octal escape and then yields a second result
// sends them in turn. A small result queue sits between the front end and
// the output stage, so input is stalled only while that queue is full.
// ----------------------------------------------------------------------------
module pdf_literal_string_decoder #(
    parameter int unsigned FIFO_DEPTH = pdf_lsd_pkg::FIFO_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [pdf_lsd_pkg::LEN_W-1:0]  cfg_wdata,   // max_length
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pdf_lsd_pkg::BYTE_W-1:0] s_tdata,     // in_byte
    input  wire logic                           s_tlast,     // stream_end
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pdf_lsd_pkg::BYTE_W-1:0]      m_tdata,     // out_byte
    output logic [pdf_lsd_pkg::KIND_W-1:0]      m_tuser,     // kind
    output logic                                m_tlast      // last
);
    import pdf_lsd_pkg::*;

    logic   q_full, q_not_empty, q_push, q_pop;
    entry_t q_in, q_head;

    pdf_lsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_end     (s_tlast),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (q_push),
        .push_entry (q_in)
    );

    pdf_lsd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    pdf_lsd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .out_kind    (m_tuser),
        .out_last    (m_tlast)
    );

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_DATA || m_tuser == KIND_END || m_tuser == KIND_ERROR))
        else $error("result kind out of range");

    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_DATA) |-> (m_tdata == '0))
        else $error("end marker or error carries a nonzero byte");

    a_first_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser == KIND_DATA))
        else $error("first of two results is not a data byte");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !s_tready)
        else $error("input accepted while the result queue is full");

endmodule
`default_nettype wire
